>>> src/tgc_pkg.sv
package tgc_pkg;

  // configuration register layout
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int MOVE_W     = 12;
  localparam int MS_W       = 16;

  localparam logic [CFG_IDX_W-1:0] REG_SWIPE_MIN   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STILL_LIMIT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_MS     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SWIPE_TIME  = 2'd3;

  localparam logic [MOVE_W-1:0] SWIPE_MIN_RST   = 12'd40;
  localparam logic [MOVE_W-1:0] STILL_LIMIT_RST = 12'd20;
  localparam logic [MS_W-1:0]   HOLD_MS_RST     = 16'd800;
  localparam logic [MS_W-1:0]   SWIPE_TIME_RST  = 16'd700;

  // reported gesture codes
  localparam int GEST_W = 3;
  localparam logic [GEST_W-1:0] GEST_TAP   = 3'd0;
  localparam logic [GEST_W-1:0] GEST_LONG  = 3'd1;
  localparam logic [GEST_W-1:0] GEST_UP    = 3'd2;
  localparam logic [GEST_W-1:0] GEST_DOWN  = 3'd3;
  localparam logic [GEST_W-1:0] GEST_LEFT  = 3'd4;
  localparam logic [GEST_W-1:0] GEST_RIGHT = 3'd5;

  // controller gesture codes
  localparam logic [7:0] CHIP_UP    = 8'h01;
  localparam logic [7:0] CHIP_DOWN  = 8'h02;
  localparam logic [7:0] CHIP_LEFT  = 8'h03;
  localparam logic [7:0] CHIP_RIGHT = 8'h04;
  localparam logic [7:0] CHIP_LONG  = 8'h0c;

  typedef struct packed {
    logic [MOVE_W-1:0] swipe_min_move;
    logic [MOVE_W-1:0] still_limit;
    logic [MS_W-1:0]   hold_ms;
    logic [MS_W-1:0]   swipe_time_ms;
  } cfg_t;

  typedef struct packed {
    logic              fire;
    logic [GEST_W-1:0] gesture;
  } result_t;

endpackage

>>> src/tgc_tracker.sv
module tgc_tracker
  import tgc_pkg::*;
#(
  parameter int COORD_BITS = 12,
  parameter int TIME_BITS  = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  advance,
  input  logic                  finger,
  input  logic [COORD_BITS-1:0] x,
  input  logic [COORD_BITS-1:0] y,
  input  logic [TIME_BITS-1:0]  now,
  input  logic [7:0]            chip,
  input  cfg_t                  cfg,
  output result_t               res
);

  localparam int MW = (COORD_BITS > MOVE_W) ? COORD_BITS : MOVE_W;

  logic                  touching;
  logic                  long_fired;
  logic [COORD_BITS-1:0] start_x_reg;
  logic [COORD_BITS-1:0] start_y_reg;
  logic [COORD_BITS-1:0] last_x_reg;
  logic [COORD_BITS-1:0] last_y_reg;
  logic [TIME_BITS-1:0]  press_stamp;

  logic [TIME_BITS-1:0]       dur;
  logic signed [COORD_BITS:0] dx;
  logic signed [COORD_BITS:0] dy;
  logic [COORD_BITS:0]        ndx;
  logic [COORD_BITS:0]        ndy;
  logic [MW-1:0]              adx;
  logic [MW-1:0]              ady;
  logic [MW-1:0]              tap;
  logic [MW-1:0]              thr;
  logic                       long_ok;
  logic                       still;
  logic                       slow;

  assign dur = now - press_stamp;
  assign dx  = $signed({1'b0, last_x_reg}) - $signed({1'b0, start_x_reg});
  assign dy  = $signed({1'b0, last_y_reg}) - $signed({1'b0, start_y_reg});
  assign ndx = -dx;
  assign ndy = -dy;
  assign adx = MW'(dx[COORD_BITS] ? ndx[COORD_BITS-1:0] : dx[COORD_BITS-1:0]);
  assign ady = MW'(dy[COORD_BITS] ? ndy[COORD_BITS-1:0] : dy[COORD_BITS-1:0]);
  assign tap = MW'(cfg.still_limit);
  assign thr = MW'(cfg.swipe_min_move);

  assign long_ok = dur >= TIME_BITS'(cfg.hold_ms);
  assign slow    = dur >  TIME_BITS'(cfg.swipe_time_ms);
  assign still   = (adx < tap) && (ady < tap);

  always_comb begin
    res.fire    = 1'b0;
    res.gesture = GEST_TAP;
    if (finger) begin
      if (touching && !long_fired && long_ok) begin
        res.fire    = 1'b1;
        res.gesture = GEST_LONG;
      end
    end else if (touching && !long_fired) begin
      if (long_ok && still) begin
        res.fire    = 1'b1;
        res.gesture = GEST_LONG;
      end else begin
        res.fire = 1'b1;
        case (chip)
          CHIP_UP:    res.gesture = GEST_UP;
          CHIP_DOWN:  res.gesture = GEST_DOWN;
          CHIP_LEFT:  res.gesture = GEST_LEFT;
          CHIP_RIGHT: res.gesture = GEST_RIGHT;
          CHIP_LONG:  res.gesture = GEST_LONG;
          default: begin
            // long and still was taken above, so still here is a tap
            if (still) begin
              res.gesture = GEST_TAP;
            end else if (slow) begin
              res.fire = 1'b0;
            end else if (adx >= ady) begin
              // axis tie goes horizontal
              res.fire    = (adx >= thr);
              res.gesture = (!dx[COORD_BITS] && (dx != '0)) ? GEST_RIGHT : GEST_LEFT;
            end else begin
              res.fire    = (ady >= thr);
              res.gesture = dy[COORD_BITS] ? GEST_UP : GEST_DOWN;
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      touching   <= 1'b0;
      long_fired <= 1'b0;
    end else if (advance) begin
      if (finger) begin
        touching <= 1'b1;
        if (!touching) begin
          long_fired <= 1'b0;
        end else if (res.fire) begin
          long_fired <= 1'b1;
        end
      end else begin
        touching <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && finger) begin
      last_x_reg <= x;
      last_y_reg <= y;
      if (!touching) begin
        start_x_reg <= x;
        start_y_reg <= y;
        press_stamp <= now;
      end
    end
  end

endmodule

>>> src/tgc_out_reg.sv
module tgc_out_reg
  import tgc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  logic [GEST_W-1:0] gesture_in,
  input  logic              out_ready,
  output logic              out_valid,
  output logic [GEST_W-1:0] gesture,
  output logic              busy
);

  // held result that the receiver has not taken yet
  assign busy = out_valid && !out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      gesture <= gesture_in;
    end
  end

endmodule

>>> src/touch_gesture_classifier.sv
// touch gesture classifier
// one item is one touch poll sample: finger_present, pos_x, pos_y, now_ms and
// the controller's own gesture code chip_gesture, taken on in_valid/in_ready
// a result item carries a gesture code on out_valid/out_ready; a sample
// gives zero or one result (long press while held, or the class on release)
// configuration: cfg_we writes cfg_data into register cfg_index
//   0 swipe_min_move, 1 still_limit, 2 hold_ms, 3 swipe_time_ms
// an accepted item is held in the input register and classified from it;
// any result is loaded into the result register, which raises out_valid
// throughput: one item per cycle unless a result waits on a blocked output;
// the path is subtracts and compares from the input to the result register
// when the receiver stalls, the result register holds; a sample that gives
// no result still passes, one that gives a result waits in the input
// register, and in_ready drops once that register is full and blocked
// reset: synchronous rst clears the finger tracking, both valid flags and
// loads the register defaults (40, 20, 800, 700)
module touch_gesture_classifier
  import tgc_pkg::*;
#(
  parameter int COORD_BITS = 12,
  parameter int TIME_BITS  = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  finger_present,
  input  logic [COORD_BITS-1:0] pos_x,
  input  logic [COORD_BITS-1:0] pos_y,
  input  logic [TIME_BITS-1:0]  now_ms,
  input  logic [7:0]            chip_gesture,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [GEST_W-1:0]     gesture,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t cfg;

  // input register
  logic                  s_valid;
  logic                  s_finger;
  logic [COORD_BITS-1:0] s_x;
  logic [COORD_BITS-1:0] s_y;
  logic [TIME_BITS-1:0]  s_now;
  logic [7:0]            s_chip;

  result_t res;
  logic    out_busy;
  logic    advance;
  logic    in_take;

  // the held sample moves on unless it has a result and the output is blocked
  assign advance  = s_valid && (!res.fire || !out_busy);
  assign in_ready = !s_valid || advance;
  assign in_take  = in_valid && in_ready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.swipe_min_move <= SWIPE_MIN_RST;
      cfg.still_limit    <= STILL_LIMIT_RST;
      cfg.hold_ms        <= HOLD_MS_RST;
      cfg.swipe_time_ms  <= SWIPE_TIME_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SWIPE_MIN:   cfg.swipe_min_move <= cfg_data[MOVE_W-1:0];
        REG_STILL_LIMIT: cfg.still_limit    <= cfg_data[MOVE_W-1:0];
        REG_HOLD_MS:     cfg.hold_ms        <= cfg_data[MS_W-1:0];
        REG_SWIPE_TIME:  cfg.swipe_time_ms  <= cfg_data[MS_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (in_take) begin
      s_valid <= 1'b1;
    end else if (advance) begin
      s_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s_finger <= finger_present;
      s_x      <= pos_x;
      s_y      <= pos_y;
      s_now    <= now_ms;
      s_chip   <= chip_gesture;
    end
  end

  // finger tracking and classification
  tgc_tracker #(
    .COORD_BITS(COORD_BITS),
    .TIME_BITS (TIME_BITS)
  ) u_tracker (
    .clk    (clk),
    .rst    (rst),
    .advance(advance),
    .finger (s_finger),
    .x      (s_x),
    .y      (s_y),
    .now    (s_now),
    .chip   (s_chip),
    .cfg    (cfg),
    .res    (res)
  );

  // result register
  tgc_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (advance && res.fire),
    .gesture_in(res.gesture),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .gesture   (gesture),
    .busy      (out_busy)
  );

  // a new result never overwrites one still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (advance && res.fire) |-> (!out_valid || out_ready))
    else $error("result register overwritten");

  // an empty input register always takes a sample
  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !s_valid |-> in_ready)
    else $error("input stalled while empty");

  // only defined gesture codes leave the block
  a_gesture_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (gesture <= GEST_RIGHT))
    else $error("undefined gesture code");

  // a held sample with no result never waits
  a_no_result_moves: assert property (@(posedge clk) disable iff (rst)
    (s_valid && !res.fire) |=> (!s_valid || $past(in_take)))
    else $error("sample without result held back");

endmodule
